/* src/vtenc_pkg.sv */
// shared types and constants of the keyboard to vt sequence encoder
// no dependencies; used by every other file of the block but vtenc_if
package vtenc_pkg;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CfgIdxW  = 3;

  // raw keyboard and host character codes
  localparam logic [7:0] KEY_FUNC  = 8'hFE;
  localparam logic [7:0] KEY_SS3   = 8'h8F;
  localparam logic [7:0] KEY_CSI   = 8'h9B;
  localparam logic [7:0] KEY_HOLD  = 8'h82;
  localparam logic [7:0] KEY_SETUP = 8'h0E;
  localparam logic [7:0] KEY_CLEAR = 8'h08;
  localparam logic [7:0] KEY_HOME  = 8'h0F;
  localparam logic [7:0] KEY_PRINT = 8'h09;
  localparam logic [7:0] KEY_BREAK = 8'h0A;
  localparam logic [7:0] KEY_F15   = 8'h07;
  localparam logic [7:0] CHR_ESC   = 8'h1B;
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_XOFF  = 8'h13;
  localparam logic [7:0] CHR_XON   = 8'h11;
  localparam logic [7:0] CHR_TILDE = 8'h7E;
  localparam logic [7:0] C1_OFFSET = 8'h40;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONLINE  = 3'd0,
    CFG_VT200   = 3'd1,
    CFG_EIGHT   = 3'd2,
    CFG_XLAT_C1 = 3'd3,
    CFG_CURSOR  = 3'd4,
    CFG_NUMERIC = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_FUNC = 2'd1,
    PFX_PAD  = 2'd2
  } pfx_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_SETUP = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_HOME  = 3'd3,
    ACT_PRINT = 3'd4
  } act_e;

  // one classified key word: the host bytes it produces and its events
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               nbytes;
    logic [2:0]               nres;
    logic                     brk;
    logic                     led_change;
    logic                     led_on;
    act_e                     action;
    logic                     udk_req;
    logic [3:0]               udk_idx;
    logic                     to_local;
  } entry_t;

endpackage

/* src/vtenc_if.sv */
// valid/ready channel interfaces for key words and result words
// depends on nothing
interface vtenc_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink (input valid, input key_byte, output ready);
endinterface

interface vtenc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       break_seen;
  logic       led_change;
  logic       led_on;
  logic [2:0] local_action;
  logic       udk_request;
  logic [3:0] udk_index;
  logic       to_local;

  modport source (
    output valid, output out_byte, output byte_valid, output last, output break_seen,
    output led_change, output led_on, output local_action, output udk_request,
    output udk_index, output to_local, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input last, input break_seen,
    input led_change, input led_on, input local_action, input udk_request,
    input udk_index, input to_local, output ready
  );
endinterface

/* src/keyboard_to_vt_sequence_encoder.sv */
// top level of the keyboard to vt sequence encoder: front, queue, back end
// depends on vtenc_pkg, vtenc_if, vtenc_front, vtenc_fifo, vtenc_back
// with an idle back end, the first result word of a key word passes through the queue and then the output register
// throughput: the back end walks the n result words of a key word in turn (n up to 5);
//   prefix bytes give none; key words are taken every cycle while a queue slot is free
// reset clears prefix, hold state, queue and output valid; config takes its defaults
module keyboard_to_vt_sequence_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vtenc_key_if.sink                     key_i,
  vtenc_res_if.source                   res_o,
  input  logic                          cfg_we_i,
  input  logic [vtenc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                          cfg_data_i
);

  // queue handshake between the classifier and the result walker
  logic              q_push, q_full, q_pop, q_valid;
  vtenc_pkg::entry_t q_wdata, q_rdata;

  // front end takes a key word whenever the queue has a free slot,
  // independent of whether the output side is stalled
  vtenc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .key_valid_i (key_i.valid),
    .key_byte_i  (key_i.key_byte),
    .key_ready_o (key_i.ready),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wdata)
  );

  // two entries decouple the classifier from a stalled host
  vtenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // back end pops an entry once its last result word is loaded
  vtenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_rdata),
    .pop_o        (q_pop),
    .res_o        (res_o)
  );

endmodule

/* src/vtenc_front.sv */
// front end: config registers, prefix/hold state, key word classification
// depends on vtenc_pkg
module vtenc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vtenc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic                              cfg_data_i,
  input  logic                              key_valid_i,
  input  logic [7:0]                        key_byte_i,
  output logic                              key_ready_o,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output vtenc_pkg::entry_t                 q_entry_o
);

  typedef struct packed {
    logic [7:0][7:0] b;
    logic [2:0]      n;
  } obuf_t;

  typedef struct packed {
    logic       hit;
    logic       shifted;
    logic [3:0] num;
  } fkey_t;

  function automatic obuf_t put(obuf_t o, logic [7:0] b);
    obuf_t r;
    r = o;
    r.b[r.n] = b;
    r.n = r.n + 3'd1;
    return r;
  endfunction

  function automatic obuf_t put_c1(obuf_t o, logic [7:0] c, logic eight, logic xlat);
    obuf_t r;
    logic  is_c1;
    r = o;
    is_c1 = (c == vtenc_pkg::KEY_SS3) || (c == vtenc_pkg::KEY_CSI);
    if (!c[7]) begin
      r = put(r, c);
    end else if (eight && !(xlat && is_c1)) begin
      r = put(r, c);
    end else if (is_c1) begin
      r = put(r, vtenc_pkg::CHR_ESC);
      r = put(r, c - vtenc_pkg::C1_OFFSET);
    end
    return r;
  endfunction

  function automatic fkey_t fkey_decode(logic [7:0] c);
    fkey_t      r;
    logic [7:0] off;
    r = '0;
    off = '0;
    if (c >= 8'h10 && c <= 8'h2D) begin
      r.hit = 1'b1;
      off = c - 8'h10;
    end else if (c >= 8'h2E && c <= 8'h4B) begin
      r.hit = 1'b1;
      off = c - 8'h2E;
    end else if (c >= 8'h4E && c <= 8'h6B) begin
      r.hit = 1'b1;
      off = c - 8'h4E;
    end
    r.shifted = off[0];
    r.num = off[4:1];
    return r;
  endfunction

  // csi parameter of function keys f6..f20 as two ascii digits
  function automatic logic [15:0] fkey_digits(logic [3:0] f);
    logic [15:0] r;
    case (f)
      4'd0:    r = "17";
      4'd1:    r = "18";
      4'd2:    r = "19";
      4'd3:    r = "20";
      4'd4:    r = "21";
      4'd5:    r = "23";
      4'd6:    r = "24";
      4'd7:    r = "25";
      4'd8:    r = "26";
      4'd9:    r = "28";
      4'd10:   r = "29";
      4'd11:   r = "31";
      4'd12:   r = "32";
      4'd13:   r = "33";
      4'd14:   r = "34";
      default: r = "00";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] edit_digit(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h04, 8'h0C: r = "1";
      8'h05, 8'h0D: r = "2";
      8'h06:        r = "3";
      8'h01:        r = "4";
      8'h02, 8'h0B: r = "5";
      8'h03, 8'h86: r = "6";
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

  // keypad table: 0 cursor key, 1 pf key, else the digit, sign or carriage return sent
  function automatic logic [7:0] pad_lookup(logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (c == 8'h4D) begin
      r = 8'h0D;
    end else if (c >= 8'h50 && c <= 8'h53) begin
      r = 8'h01;
    end else if (c >= 8'h6C && c <= 8'h6E) begin
      r = c - 8'h40;
    end else if (c >= 8'h70 && c <= 8'h79) begin
      r = c - 8'h40;
    end
    return r;
  endfunction

  logic online_q, vt200_q, eight_q, xlat_q, cursor_q, numeric_q;
  vtenc_pkg::pfx_e prefix_q, prefix_d;
  logic hold_q, hold_d;
  logic accept;

  assign key_ready_o = !q_full_i;
  assign accept = key_valid_i && key_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q  <= 1'b1;
      vt200_q   <= 1'b1;
      eight_q   <= 1'b0;
      xlat_q    <= 1'b1;
      cursor_q  <= 1'b1;
      numeric_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vtenc_pkg::CFG_ONLINE:  online_q  <= cfg_data_i;
        vtenc_pkg::CFG_VT200:   vt200_q   <= cfg_data_i;
        vtenc_pkg::CFG_EIGHT:   eight_q   <= cfg_data_i;
        vtenc_pkg::CFG_XLAT_C1: xlat_q    <= cfg_data_i;
        vtenc_pkg::CFG_CURSOR:  cursor_q  <= cfg_data_i;
        vtenc_pkg::CFG_NUMERIC: numeric_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= vtenc_pkg::PFX_NONE;
      hold_q   <= 1'b0;
    end else if (accept) begin
      prefix_q <= prefix_d;
      hold_q   <= hold_d;
    end
  end

  // next prefix and hold state
  always_comb begin
    prefix_d = vtenc_pkg::PFX_NONE;
    hold_d   = hold_q;
    if (prefix_q == vtenc_pkg::PFX_NONE) begin
      if (key_byte_i == vtenc_pkg::KEY_FUNC) begin
        prefix_d = vtenc_pkg::PFX_FUNC;
      end else if (key_byte_i == vtenc_pkg::KEY_SS3) begin
        prefix_d = vtenc_pkg::PFX_PAD;
      end else if (key_byte_i == vtenc_pkg::KEY_HOLD) begin
        hold_d = !hold_q;
      end else begin
        hold_d = 1'b0;
      end
    end
  end

  // classification of the key word into bytes and events
  obuf_t           ob;
  fkey_t           fk;
  logic [7:0]      dig;
  logic [7:0]      pad;
  logic [15:0]     fdig;
  logic [7:0]      lead;
  vtenc_pkg::entry_t ent;
  logic            any_event;

  always_comb begin
    ob   = '0;
    ent  = '0;
    fk   = fkey_decode(key_byte_i);
    dig  = edit_digit(key_byte_i);
    pad  = pad_lookup(key_byte_i);
    fdig = '0;
    lead = cursor_q ? vtenc_pkg::KEY_CSI : vtenc_pkg::KEY_SS3;
    ent.action = vtenc_pkg::ACT_NONE;
    case (prefix_q)
      vtenc_pkg::PFX_FUNC: begin
        if (key_byte_i == vtenc_pkg::KEY_SETUP) begin
          ent.action = vtenc_pkg::ACT_SETUP;
        end else if (key_byte_i == vtenc_pkg::KEY_CLEAR) begin
          ent.action = vtenc_pkg::ACT_CLEAR;
        end else if (key_byte_i == vtenc_pkg::KEY_HOME) begin
          ent.action = vtenc_pkg::ACT_HOME;
        end else if (key_byte_i == vtenc_pkg::KEY_PRINT) begin
          ent.action = vtenc_pkg::ACT_PRINT;
        end else if (online_q && vt200_q) begin
          if (key_byte_i == vtenc_pkg::KEY_F15) begin
            fk.hit = 1'b1;
            fk.shifted = 1'b0;
            fk.num = 4'd9;
          end
          fdig = fkey_digits(fk.num);
          if (key_byte_i == vtenc_pkg::KEY_BREAK) begin
            ent.brk = 1'b1;
          end else if (dig != 8'h00) begin
            ob = put_c1(ob, vtenc_pkg::KEY_CSI, eight_q, xlat_q);
            ob = put(ob, dig);
            ob = put(ob, vtenc_pkg::CHR_TILDE);
          end else if (fk.hit && !fk.shifted) begin
            ob = put_c1(ob, vtenc_pkg::KEY_CSI, eight_q, xlat_q);
            ob = put(ob, fdig[15:8]);
            ob = put(ob, fdig[7:0]);
            ob = put(ob, vtenc_pkg::CHR_TILDE);
          end else if (fk.hit) begin
            ent.udk_req = 1'b1;
            ent.udk_idx = fk.num;
          end
        end else if (online_q && fk.hit) begin
          // older mapping: f11, f12, f13
          if (fk.num == 4'd5) begin
            ob = put(ob, vtenc_pkg::CHR_ESC);
          end else if (fk.num == 4'd6) begin
            ob = put(ob, vtenc_pkg::CHR_BS);
          end else if (fk.num == 4'd7) begin
            ob = put(ob, vtenc_pkg::CHR_LF);
          end
        end
      end
      vtenc_pkg::PFX_PAD: begin
        if (pad == 8'h00) begin
          ob = put_c1(ob, lead, eight_q, xlat_q);
          ob = put(ob, key_byte_i);
        end else if (pad == 8'h01 || !numeric_q) begin
          ob = put_c1(ob, vtenc_pkg::KEY_SS3, eight_q, xlat_q);
          ob = put(ob, key_byte_i);
        end else begin
          ob = put(ob, pad);
        end
      end
      vtenc_pkg::PFX_NONE: begin
        if (key_byte_i == vtenc_pkg::KEY_HOLD) begin
          ob = put(ob, hold_q ? vtenc_pkg::CHR_XON : vtenc_pkg::CHR_XOFF);
          ent.led_change = 1'b1;
          ent.led_on = !hold_q;
        end else if (key_byte_i != vtenc_pkg::KEY_FUNC && key_byte_i != vtenc_pkg::KEY_SS3) begin
          ob = put_c1(ob, key_byte_i, eight_q, xlat_q);
          ent.led_change = hold_q;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < vtenc_pkg::MaxBytes; i++) begin
      ent.bytes[i] = ob.b[i];
    end
    ent.nbytes   = ob.n;
    ent.to_local = !online_q;
    any_event = ent.brk || ent.led_change || ent.udk_req ||
                (ent.action != vtenc_pkg::ACT_NONE);
    ent.nres = (ob.n != 3'd0) ? ob.n : {2'b00, any_event};
  end

  assign q_entry_o = ent;
  assign q_push_o  = accept && (ent.nres != 3'd0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("front pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && prefix_q != vtenc_pkg::PFX_NONE) |=> prefix_q == vtenc_pkg::PFX_NONE)
    else $error("prefix survived its key byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> q_entry_o.nbytes <= 3'd5)
    else $error("classified word overflows the byte list");

endmodule

/* src/vtenc_fifo.sv */
// two-entry queue of classified key words between front and back end
// depends on vtenc_pkg
module vtenc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vtenc_pkg::entry_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output vtenc_pkg::entry_t data_o
);

  vtenc_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("full queue with pointers apart");

endmodule

/* src/vtenc_back.sv */
// back end: walks the head queue entry and emits one result word per cycle while the host takes them
// depends on vtenc_pkg, vtenc_if
module vtenc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  vtenc_pkg::entry_t head_i,
  output logic              pop_o,
  vtenc_res_if.source       res_o
);

  logic [2:0] idx_q, idx_d;
  logic       load, fin, has_byte;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       byte_valid_q, last_q, brk_q, ledch_q, ledon_q, udk_q, local_q;
  logic [2:0] action_q;
  logic [3:0] udk_idx_q;

  assign load     = !out_valid_q || res_o.ready;
  assign fin      = (idx_q == head_i.nres - 3'd1);
  assign has_byte = (idx_q < head_i.nbytes);
  assign pop_o    = load && head_valid_i && fin;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        idx_d = fin ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_byte_q   <= has_byte ? head_i.bytes[idx_q] : 8'h00;
      byte_valid_q <= has_byte;
      last_q       <= fin;
      brk_q        <= fin && head_i.brk;
      ledch_q      <= fin && head_i.led_change;
      ledon_q      <= fin && head_i.led_on;
      action_q     <= fin ? head_i.action : vtenc_pkg::ACT_NONE;
      udk_q        <= fin && head_i.udk_req;
      udk_idx_q    <= fin ? head_i.udk_idx : 4'd0;
      local_q      <= has_byte && head_i.to_local;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_byte     = out_byte_q;
  assign res_o.byte_valid   = byte_valid_q;
  assign res_o.last         = last_q;
  assign res_o.break_seen   = brk_q;
  assign res_o.led_change   = ledch_q;
  assign res_o.led_on       = ledon_q;
  assign res_o.local_action = action_q;
  assign res_o.udk_request  = udk_q;
  assign res_o.udk_index    = udk_idx_q;
  assign res_o.to_local     = local_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !byte_valid_q) |-> last_q)
    else $error("byteless result word that is not the last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_i.nres))
    else $error("result index ran past the entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 3'd0))
    else $error("result index left over with an empty queue");

endmodule
